// File: hdl/mwo_pkg.sv
// Shared widths, limits and codes of the morphing wavetable oscillator.
package mwo_pkg;

    localparam int PHASE_W  = 32;
    localparam int STEP_W   = 31;
    localparam int MORPH_W  = 17;
    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int SEL_W    = 7;
    localparam int ENTRY_W  = 8;

    localparam int TABLE_COUNT_DEF  = 128;
    localparam int TABLE_LENGTH_DEF = 256;

    localparam logic [STEP_W-1:0]  STEP_LIMIT = 31'd1932735283;
    localparam logic [MORPH_W-1:0] MORPH_ONE  = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MORPH      = 1'b1;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

endpackage

// File: hdl/mwo_ram.sv
// Generic simple dual-port RAM with registered read data.
module mwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/mwo_blend.sv
// Shared interpolation unit: a + floor(w * (b - a) / 65536).
module mwo_blend (
    input  logic signed [mwo_pkg::SAMPLE_W-1:0] i_a,
    input  logic signed [mwo_pkg::SAMPLE_W-1:0] i_b,
    input  logic        [mwo_pkg::WEIGHT_W-1:0] i_w,
    output logic signed [mwo_pkg::SAMPLE_W-1:0] o_y
);

    localparam int DW = mwo_pkg::SAMPLE_W + 1;
    localparam int PW = DW + mwo_pkg::WEIGHT_W + 1;
    localparam int QW = PW - mwo_pkg::WEIGHT_W;

    logic signed [DW-1:0] diff;
    logic signed [mwo_pkg::WEIGHT_W:0] weight;
    logic signed [PW-1:0] prod;
    logic signed [QW-1:0] quot;
    logic signed [QW-1:0] sum;

    always_comb begin
        diff   = DW'(i_b) - DW'(i_a);
        weight = $signed({1'b0, i_w});
        prod   = PW'(diff) * PW'(weight);
        quot   = prod[PW-1:mwo_pkg::WEIGHT_W];
        sum    = QW'(i_a) + quot;
        o_y    = sum[mwo_pkg::SAMPLE_W-1:0];
    end

endmodule

// File: hdl/morphing_wavetable_oscillator.sv
// Top level of the morphing wavetable oscillator: sequencer, phase and table store.
//
// Input items arrive on i_valid/o_ready. An item with i_kind low writes one
// word into the table store; an out-of-range table or entry is dropped. It
// gives no result. An item with i_kind high asks for one sample: the phase
// advances by the clamped step, state S_POS forms the table position, four
// table words are read in turn (state S_RD) through the registered read port
// of the table memory, and the shared interpolation unit runs three times in
// a row (two table lookups, then the crossfade). The block takes no new item
// until the sample has entered the output register.
// Results leave on o_valid/i_ready from an output register. If the receiver
// stalls, the next sample waits in its last step until the register frees.
// The configuration port writes the phase step (index 0) and the morph
// position (index 1), with no read-back.
// Reset clears phase, step, morph and control state. The table store is not
// cleared; it must be loaded before samples are requested.
module morphing_wavetable_oscillator #(
    parameter int TABLE_COUNT  = mwo_pkg::TABLE_COUNT_DEF,
    parameter int TABLE_LENGTH = mwo_pkg::TABLE_LENGTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mwo_pkg::CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [mwo_pkg::STEP_W-1:0]            i_cfg_wdata,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_kind,
    input  logic [mwo_pkg::SEL_W-1:0]             i_table_select,
    input  logic [mwo_pkg::ENTRY_W-1:0]           i_entry_index,
    input  logic signed [mwo_pkg::SAMPLE_W-1:0]   i_table_word,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [mwo_pkg::SAMPLE_W-1:0]   o_sample
);

    localparam int TW  = $clog2(TABLE_COUNT);
    localparam int IW  = $clog2(TABLE_LENGTH);
    localparam int AW  = TW + IW;
    localparam int PW  = mwo_pkg::PHASE_W + IW;
    localparam int TPW = mwo_pkg::MORPH_W + TW;
    localparam int SW  = mwo_pkg::SAMPLE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_RD,
        S_B0,
        S_B1,
        S_B2
    } t_state;

    t_state r_state;

    logic [mwo_pkg::STEP_W-1:0]  r_step;
    logic [mwo_pkg::MORPH_W-1:0] r_morph;
    logic [mwo_pkg::PHASE_W-1:0] r_phase;
    logic [TW-1:0]               r_t0;
    logic [TW-1:0]               r_t1;
    logic [mwo_pkg::WEIGHT_W-1:0] r_g;
    logic [IW-1:0]               r_i0;
    logic [IW-1:0]               r_i1;
    logic [mwo_pkg::WEIGHT_W-1:0] r_f;
    logic [2:0]                  r_cnt;
    logic signed [SW-1:0]        r_word [4];
    logic signed [SW-1:0]        r_s0;
    logic signed [SW-1:0]        r_s1;
    logic                        r_ovalid;
    logic signed [SW-1:0]        r_sample;

    logic                        accept;
    logic                        in_range;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [AW-1:0]               mem_raddr;
    logic [SW-1:0]               mem_rdata;
    logic [mwo_pkg::STEP_W-1:0]  step_c;
    logic [mwo_pkg::MORPH_W-1:0] morph_c;
    logic [TPW-1:0]              tp;
    logic [TW:0]                 t0_full;
    logic [TW-1:0]               t0_c;
    logic [TW-1:0]               t1_c;
    logic [PW-1:0]               pos;
    logic [IW-1:0]               i0_c;
    logic [IW:0]                 i0_inc;
    logic [IW-1:0]               i1_c;
    logic signed [SW-1:0]        blend_a;
    logic signed [SW-1:0]        blend_b;
    logic [mwo_pkg::WEIGHT_W-1:0] blend_w;
    logic signed [SW-1:0]        blend_y;
    logic                        emit;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign in_range = (int'(i_table_select) < TABLE_COUNT) &&
                      (int'(i_entry_index) < TABLE_LENGTH);
    assign mem_we    = accept && (i_kind == mwo_pkg::KIND_LOAD) && in_range;
    assign mem_waddr = {TW'(i_table_select), IW'(i_entry_index)};
    assign mem_raddr = {(r_cnt[1] ? r_t1 : r_t0), (r_cnt[0] ? r_i1 : r_i0)};

    mwo_ram #(
        .WIDTH(SW),
        .DEPTH(2 ** AW)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(i_table_word),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_comb begin
        step_c  = (r_step > mwo_pkg::STEP_LIMIT) ? mwo_pkg::STEP_LIMIT : r_step;
        morph_c = (r_morph > mwo_pkg::MORPH_ONE) ? mwo_pkg::MORPH_ONE : r_morph;
        tp      = TPW'(morph_c) * TPW'(TABLE_COUNT - 1);
        t0_full = tp[TPW-1:mwo_pkg::WEIGHT_W];
        t0_c    = (int'(t0_full) > TABLE_COUNT - 1) ? TW'(TABLE_COUNT - 1) : t0_full[TW-1:0];
        t1_c    = (int'(t0_c) == TABLE_COUNT - 1) ? t0_c : t0_c + TW'(1);
        pos     = PW'(r_phase) * PW'(TABLE_LENGTH);
        i0_c    = pos[PW-1:mwo_pkg::PHASE_W];
        i0_inc  = {1'b0, i0_c} + (IW + 1)'(1);
        i1_c    = (int'(i0_inc) >= TABLE_LENGTH) ? '0 : i0_inc[IW-1:0];
    end

    always_comb begin
        unique case (r_state)
            S_B1: begin
                blend_a = r_word[2];
                blend_b = r_word[3];
                blend_w = r_f;
            end
            S_B2: begin
                blend_a = r_s0;
                blend_b = r_s1;
                blend_w = r_g;
            end
            default: begin
                blend_a = r_word[0];
                blend_b = r_word[1];
                blend_w = r_f;
            end
        endcase
    end

    mwo_blend u_blend (
        .i_a(blend_a),
        .i_b(blend_b),
        .i_w(blend_w),
        .o_y(blend_y)
    );

    assign emit = (r_state == S_B2) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_morph  <= '0;
            r_phase  <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    mwo_pkg::REG_PHASE_STEP: r_step <= i_cfg_wdata;
                    mwo_pkg::REG_MORPH:      r_morph <= i_cfg_wdata[mwo_pkg::MORPH_W-1:0];
                    default: ;
                endcase
            end

            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_kind == mwo_pkg::KIND_SAMPLE)) begin
                        r_phase <= r_phase + mwo_pkg::PHASE_W'(step_c);
                        r_t0    <= t0_c;
                        r_t1    <= t1_c;
                        r_g     <= tp[mwo_pkg::WEIGHT_W-1:0];
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    r_i0    <= i0_c;
                    r_i1    <= i1_c;
                    r_f     <= pos[mwo_pkg::PHASE_W-1:mwo_pkg::PHASE_W-mwo_pkg::WEIGHT_W];
                    r_cnt   <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    if (r_cnt != 3'd0) begin
                        r_word[r_cnt[1:0] - 2'd1] <= mem_rdata;
                    end
                    if (r_cnt == 3'd4) begin
                        r_state <= S_B0;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_B0: begin
                    r_s0    <= blend_y;
                    r_state <= S_B1;
                end
                S_B1: begin
                    r_s1    <= blend_y;
                    r_state <= S_B2;
                end
                S_B2: begin
                    if (emit) begin
                        r_sample <= blend_y;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_sample = r_sample;

endmodule

// File: test/tb_morphing_wavetable_oscillator.sv
// Self-checking testbench of the morphing wavetable oscillator with a bit-exact sample predictor.
module tb_morphing_wavetable_oscillator;

    localparam int TBL_COUNT = mwo_pkg::TABLE_COUNT_DEF;
    localparam int TBL_LEN   = mwo_pkg::TABLE_LENGTH_DEF;
    localparam int MORPH_LO_MAX = 65535 / (TBL_COUNT - 1);
    localparam int MORPH_HI_MIN = ((TBL_COUNT - 2) * 65536 + TBL_COUNT - 2) / (TBL_COUNT - 1);
    localparam logic [mwo_pkg::STEP_W-1:0] STEP_MAX = '1;

    typedef struct {
        logic                                kind;
        logic [mwo_pkg::SEL_W-1:0]           sel;
        logic [mwo_pkg::ENTRY_W-1:0]         entry;
        logic signed [mwo_pkg::SAMPLE_W-1:0] word;
    } t_osc_item;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_we = 1'b0;
    logic [mwo_pkg::CFG_IDX_W-1:0]        i_cfg_addr = mwo_pkg::REG_PHASE_STEP;
    logic [mwo_pkg::STEP_W-1:0]           i_cfg_wdata = '0;
    logic                                 i_valid = 1'b0;
    logic                                 o_ready;
    logic                                 i_kind = mwo_pkg::KIND_LOAD;
    logic [mwo_pkg::SEL_W-1:0]            i_table_select = '0;
    logic [mwo_pkg::ENTRY_W-1:0]          i_entry_index = '0;
    logic signed [mwo_pkg::SAMPLE_W-1:0]  i_table_word = '0;
    logic                                 o_valid;
    logic                                 i_ready = 1'b0;
    logic signed [mwo_pkg::SAMPLE_W-1:0]  o_sample;

    t_osc_item                            pending_items[$];
    logic signed [mwo_pkg::SAMPLE_W-1:0]  expected_samples[$];
    logic signed [mwo_pkg::SAMPLE_W-1:0]  wave_words[TBL_COUNT*TBL_LEN];
    logic [mwo_pkg::PHASE_W-1:0]          osc_phase = '0;
    logic [mwo_pkg::STEP_W-1:0]           cur_step = '0;
    logic [mwo_pkg::MORPH_W-1:0]          cur_morph = '0;
    int                                   filled_tables[4] = '{0, 1, TBL_COUNT - 2, TBL_COUNT - 1};
    bit                                   steady = 1'b0;
    int                                   fail_count = 0;

    morphing_wavetable_oscillator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_table_select (i_table_select),
        .i_entry_index  (i_entry_index),
        .i_table_word   (i_table_word),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample       (o_sample)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int lerp_floor(int a, int b, int w);
        longint d;
        d = longint'(b - a) * longint'(w);
        return a + int'(d >>> 16);
    endfunction

    function automatic int word_at(int t, int i);
        return int'(wave_words[t * TBL_LEN + i]);
    endfunction

    function automatic logic signed [mwo_pkg::SAMPLE_W-1:0] next_sample();
        logic [mwo_pkg::PHASE_W-1:0] step;
        logic [63:0]                 pos;
        logic [63:0]                 tp;
        logic [31:0]                 m;
        int                          i0, i1, f, t0, t1, g, s0, s1;
        step = (cur_step > mwo_pkg::STEP_LIMIT) ? mwo_pkg::PHASE_W'(mwo_pkg::STEP_LIMIT)
                                                : mwo_pkg::PHASE_W'(cur_step);
        osc_phase = osc_phase + step;
        pos = 64'(osc_phase) * 64'(TBL_LEN);
        i0 = int'(pos >> 32);
        i1 = (i0 + 1 >= TBL_LEN) ? 0 : i0 + 1;
        f = int'(pos[31:16]);
        m = (cur_morph > mwo_pkg::MORPH_ONE) ? 32'(mwo_pkg::MORPH_ONE) : 32'(cur_morph);
        tp = 64'(m) * 64'(TBL_COUNT - 1);
        t0 = int'(tp >> 16);
        g = int'(tp[15:0]);
        if (t0 > TBL_COUNT - 1) begin
            t0 = TBL_COUNT - 1;
        end
        t1 = (t0 + 1 > TBL_COUNT - 1) ? TBL_COUNT - 1 : t0 + 1;
        s0 = lerp_floor(word_at(t0, i0), word_at(t0, i1), f);
        s1 = lerp_floor(word_at(t1, i0), word_at(t1, i1), f);
        return mwo_pkg::SAMPLE_W'(lerp_floor(s0, s1, g));
    endfunction

    function automatic t_osc_item load_item(int sel, int entry, int word);
        t_osc_item it;
        it.kind = mwo_pkg::KIND_LOAD;
        it.sel = mwo_pkg::SEL_W'(sel);
        it.entry = mwo_pkg::ENTRY_W'(entry);
        it.word = mwo_pkg::SAMPLE_W'(word);
        return it;
    endfunction

    function automatic t_osc_item sample_item();
        t_osc_item it;
        it.kind = mwo_pkg::KIND_SAMPLE;
        it.sel = mwo_pkg::SEL_W'($urandom);
        it.entry = mwo_pkg::ENTRY_W'($urandom);
        it.word = mwo_pkg::SAMPLE_W'($urandom);
        return it;
    endfunction

    function automatic int random_word();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            default: return int'($urandom & 32'hFFFF);
        endcase
    endfunction

    // The morph position is kept where it selects only the filled tables at either end.
    function automatic logic [mwo_pkg::STEP_W-1:0] random_morph();
        case ($urandom_range(0, 4))
            0: return mwo_pkg::STEP_W'($urandom_range(0, MORPH_LO_MAX));
            1: return mwo_pkg::STEP_W'($urandom_range(MORPH_HI_MIN, 65536));
            2: return mwo_pkg::STEP_W'($urandom_range(65537, 131071));
            3: return mwo_pkg::STEP_W'(mwo_pkg::MORPH_ONE);
            default: return '0;
        endcase
    endfunction

    function automatic logic [mwo_pkg::STEP_W-1:0] random_step();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return mwo_pkg::STEP_W'($urandom_range(1, 1 << 20));
            2: return mwo_pkg::STEP_W'($urandom);
            3: return mwo_pkg::STEP_LIMIT;
            4: return mwo_pkg::STEP_W'($urandom_range(int'(mwo_pkg::STEP_LIMIT) + 1,
                                                      int'(STEP_MAX)));
            default: return mwo_pkg::STEP_W'($urandom_range(1, 115)) << 24;
        endcase
    endfunction

    task automatic write_reg(input logic [mwo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mwo_pkg::STEP_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        if (idx == mwo_pkg::REG_PHASE_STEP) begin
            cur_step = val;
        end else begin
            cur_morph = val[mwo_pkg::MORPH_W-1:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_items.size() != 0 || i_valid || expected_samples.size() != 0);
        repeat (12) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_osc_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                if (i_kind == mwo_pkg::KIND_LOAD) begin
                    if (int'(i_table_select) < TBL_COUNT && int'(i_entry_index) < TBL_LEN) begin
                        wave_words[int'(i_table_select) * TBL_LEN + int'(i_entry_index)] =
                            i_table_word;
                    end
                end else begin
                    expected_samples.push_back(next_sample());
                end
            end
            if (!i_valid || o_ready) begin
                if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 30)) begin
                    nxt = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_kind <= nxt.kind;
                    i_table_select <= nxt.sel;
                    i_entry_index <= nxt.entry;
                    i_table_word <= nxt.word;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        logic signed [mwo_pkg::SAMPLE_W-1:0] want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("sample: no item pending, actual %0d", o_sample);
                    fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (o_sample !== want) begin
                        $error("sample mismatch: expected %0d, actual %0d", want, o_sample);
                        fail_count++;
                    end
                end
            end
            i_ready <= steady || $urandom_range(0, 99) >= 30;
        end
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(mwo_pkg::REG_PHASE_STEP, '0);
        write_reg(mwo_pkg::REG_MORPH, '0);

        foreach (filled_tables[k]) begin
            for (int e = 0; e < TBL_LEN; e++) begin
                pending_items.push_back(load_item(filled_tables[k], e, random_word()));
            end
        end
        pending_items.push_back(sample_item());
        pending_items.push_back(load_item(0, 0, -32768));
        pending_items.push_back(load_item(1, 0, 32767));
        pending_items.push_back(load_item(0, 1, 32767));
        pending_items.push_back(load_item(TBL_COUNT - 1, TBL_LEN - 1, -32768));
        pending_items.push_back(load_item(TBL_COUNT - 1, 0, 32767));
        pending_items.push_back(sample_item());
        drain();

        write_reg(mwo_pkg::REG_PHASE_STEP, STEP_MAX);
        write_reg(mwo_pkg::REG_MORPH, mwo_pkg::STEP_W'(131071));
        repeat (4) pending_items.push_back(sample_item());
        drain();

        write_reg(mwo_pkg::REG_PHASE_STEP, mwo_pkg::STEP_W'((1 << 24) - 1));
        write_reg(mwo_pkg::REG_MORPH, mwo_pkg::STEP_W'(MORPH_LO_MAX));
        repeat (4) pending_items.push_back(sample_item());
        drain();

        write_reg(mwo_pkg::REG_PHASE_STEP, mwo_pkg::STEP_LIMIT);
        write_reg(mwo_pkg::REG_MORPH, mwo_pkg::STEP_W'(MORPH_HI_MIN));
        repeat (3) pending_items.push_back(sample_item());
        pending_items.push_back(load_item(TBL_COUNT - 2, $urandom_range(0, TBL_LEN - 1),
                                          random_word()));
        pending_items.push_back(sample_item());
        drain();

        for (int p = 0; p < 8; p++) begin
            steady = (p == 3);
            write_reg(mwo_pkg::REG_PHASE_STEP, random_step());
            write_reg(mwo_pkg::REG_MORPH, random_morph());
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 99) < 70) begin
                    pending_items.push_back(sample_item());
                end else if ($urandom_range(0, 1) == 0) begin
                    pending_items.push_back(load_item(filled_tables[$urandom_range(0, 3)],
                                                      $urandom_range(0, TBL_LEN - 1),
                                                      random_word()));
                end else begin
                    pending_items.push_back(load_item($urandom_range(0, TBL_COUNT - 1),
                                                      $urandom_range(0, TBL_LEN - 1),
                                                      random_word()));
                end
            end
            drain();
        end

        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
